>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define W_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// expression must never be true outside reset
`define W_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define W_ASSERT(lbl, clk, rstn, prop, msg)
`define W_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

>>> hw/rtl/w512_pkg.sv
// ----------------------------------------------------------------------------
// w512_pkg
// shared types and constants of the well512a generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package w512_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned FracW  = 23;
  localparam int unsigned MultW  = 15;
  localparam int unsigned CntW   = 5;

  localparam logic [WordW-1:0] WellMask = 32'hda442d24;
  localparam logic [MultW-1:0] FracMult = 15'd16807;

  typedef enum logic [1:0] {
    REQ_SEED  = 2'd0,
    REQ_RAW   = 2'd1,
    REQ_RANGE = 2'd2,
    REQ_FRAC  = 2'd3
  } w512_req_e;

  typedef enum logic [1:0] {
    OFF_I,
    OFF_13,
    OFF_9,
    OFF_15
  } w512_off_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_CAP,
    ST_MIX,
    ST_WR0,
    ST_WR1,
    ST_POST,
    ST_DIV,
    ST_FIN
  } w512_state_e;

  typedef struct packed {
    logic      seed_wr;
    logic      req_load;
    w512_off_e rd_off;
    logic      cap_v0;
    logic      cap_vm1;
    logic      cap_vm2;
    logic      cap_z0;
    logic      mix;
    logic      wr0;
    logic      wr1;
    logic      div_start;
    logic      div_step;
    logic      frac_mul;
    logic      out_load;
  } w512_cmd_t;

  typedef struct packed {
    w512_req_e in_kind;
    w512_req_e kind;
    logic      div_zero;
    logic      div_last;
    logic      out_free;
  } w512_sts_t;

endpackage

>>> hw/rtl/w512_datapath.sv
// ----------------------------------------------------------------------------
// w512_datapath
// state pool, recurrence, serial remainder unit, fraction multiply, output reg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module w512_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  w512_pkg::w512_cmd_t                    cmd_i,
  output w512_pkg::w512_sts_t                    sts_o,
  input  logic [1:0]                             req_type_i,
  input  logic [w512_pkg::WordW-1:0]             lo_bound_i,
  input  logic [w512_pkg::WordW-1:0]             hi_bound_i,
  input  logic [w512_pkg::IdxW-1:0]              seed_index_i,
  input  logic [w512_pkg::WordW-1:0]             seed_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [w512_pkg::WordW-1:0]             rand_value_o,
  output logic [w512_pkg::FracW-1:0]             unit_fraction_o,
  output logic                                   bad_request_o
);
  import w512_pkg::*;

  localparam int unsigned Depth = 1 << IdxW;

  logic [WordW-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [WordW-1:0] rd_q;
  logic             rd_vld_q;
  logic [WordW-1:0] rd_word;

  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  raddr;
  logic [IdxW-1:0]  waddr;
  logic [WordW-1:0] wdata;
  logic             we;

  w512_req_e        kind_q;
  logic [WordW-1:0] lo_q;
  logic [WordW-1:0] div_q;
  logic             div_zero_q;

  logic [WordW-1:0] v0_q, vm1_q, vm2_q, z0_q;
  logic [WordW-1:0] z1, z2, n1, n0;
  logic [WordW-1:0] n1_q, n0_q;

  logic [WordW-1:0] sh_q;
  logic [WordW-1:0] rem_q;
  logic [CntW-1:0]  cnt_q;
  logic [WordW:0]   trial;
  logic [WordW:0]   diff;

  logic [FracW-1:0] m_q;
  logic [FracW+MultW-1:0] prod;

  logic             out_valid_q;
  logic [WordW-1:0] out_val_q;
  logic [FracW-1:0] out_frac_q;
  logic             out_bad_q;
  logic [WordW-1:0] fin_val;
  logic [FracW-1:0] fin_frac;
  logic             fin_bad;

  // pool memory addressing
  always_comb begin
    case (cmd_i.rd_off)
      OFF_I:   raddr = idx_q;
      OFF_13:  raddr = idx_q + IdxW'(13);
      OFF_9:   raddr = idx_q + IdxW'(9);
      OFF_15:  raddr = idx_q + IdxW'(15);
      default: raddr = idx_q;
    endcase
  end

  always_comb begin
    we    = cmd_i.seed_wr | cmd_i.wr0 | cmd_i.wr1;
    waddr = idx_q;
    wdata = n1_q;
    if (cmd_i.seed_wr) begin
      waddr = seed_index_i;
      wdata = seed_value_i;
    end else if (cmd_i.wr1) begin
      waddr = idx_q + IdxW'(15);
      wdata = n0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // words never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr];
      if (cmd_i.wr1) begin
        idx_q <= idx_q + IdxW'(15);
      end
    end
  end

  assign rd_word = rd_vld_q ? rd_q : '0;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      kind_q     <= w512_req_e'(req_type_i);
      lo_q       <= lo_bound_i;
      div_q      <= hi_bound_i - lo_bound_i;
      div_zero_q <= (hi_bound_i == lo_bound_i);
    end
  end

  // recurrence
  assign z1 = v0_q ^ (v0_q << 16) ^ vm1_q ^ (vm1_q << 15);
  assign z2 = vm2_q ^ (vm2_q >> 11);
  assign n1 = z1 ^ z2;
  assign n0 = z0_q ^ (z0_q << 2) ^ z1 ^ (z1 << 18) ^ (z2 << 28)
              ^ n1 ^ ((n1 << 5) & WellMask);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_v0) begin
      v0_q <= rd_word;
    end
    if (cmd_i.cap_vm1) begin
      vm1_q <= rd_word;
    end
    if (cmd_i.cap_vm2) begin
      vm2_q <= rd_word;
    end
    if (cmd_i.cap_z0) begin
      z0_q <= rd_word;
    end
    if (cmd_i.mix) begin
      n1_q <= n1;
      n0_q <= n0;
    end
  end

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_q, sh_q[WordW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      sh_q  <= n0_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      sh_q  <= {sh_q[WordW-2:0], 1'b0};
      rem_q <= diff[WordW] ? trial[WordW-1:0] : diff[WordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // fraction product, low bits only
  assign prod = n0_q[FracW-1:0] * FracMult;

  always_ff @(posedge clk_i) begin
    if (cmd_i.frac_mul) begin
      m_q <= prod[FracW-1:0];
    end
  end

  // result select
  always_comb begin
    fin_val  = '0;
    fin_frac = '0;
    fin_bad  = 1'b0;
    case (kind_q)
      REQ_RAW: begin
        fin_val = n0_q;
      end
      REQ_RANGE: begin
        fin_bad = div_zero_q;
        if (!div_zero_q) begin
          fin_val = lo_q + rem_q;
        end
      end
      REQ_FRAC: begin
        fin_bad = (m_q == '0);
        if (m_q != '0) begin
          fin_frac = m_q - FracW'(1);
        end
      end
      default: begin
        fin_val = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_val_q  <= fin_val;
      out_frac_q <= fin_frac;
      out_bad_q  <= fin_bad;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign rand_value_o    = out_val_q;
  assign unit_fraction_o = out_frac_q;
  assign bad_request_o   = out_bad_q;

  assign sts_o.in_kind  = w512_req_e'(req_type_i);
  assign sts_o.kind     = kind_q;
  assign sts_o.div_zero = div_zero_q;
  assign sts_o.div_last = (cnt_q == CntW'(Depth * 2 - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  `W_ASSERT(a_load_free, clk_i, rst_ni, cmd_i.out_load |-> (!out_valid_q || out_ready_i), "result overwritten before transaction")
  `W_ASSERT(a_rem_bound, clk_i, rst_ni, (cmd_i.out_load && kind_q == REQ_RANGE && !div_zero_q) |-> (rem_q < div_q), "remainder not below divisor")
  `W_ASSERT_NEVER(a_wr_clash, clk_i, rst_ni, cmd_i.seed_wr && (cmd_i.wr0 || cmd_i.wr1), "seed write during pool update")
  `W_ASSERT(a_idx_step, clk_i, rst_ni, cmd_i.wr1 |=> (idx_q == $past(idx_q) + IdxW'(15)), "index did not step")

endmodule

>>> hw/rtl/w512_ctrl.sv
// ----------------------------------------------------------------------------
// w512_ctrl
// request sequencer: pool reads, update writes, remainder loop, result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module w512_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  w512_pkg::w512_sts_t sts_i,
  output w512_pkg::w512_cmd_t cmd_o
);
  import w512_pkg::*;

  w512_state_e state_q, state_d;
  logic        accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.in_kind != REQ_SEED) begin
          state_d = ST_RD0;
        end
      end
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_RD3;
      ST_RD3:  state_d = ST_CAP;
      ST_CAP:  state_d = ST_MIX;
      ST_MIX:  state_d = ST_WR0;
      ST_WR0:  state_d = ST_WR1;
      ST_WR1:  state_d = ST_POST;
      ST_POST: begin
        if (sts_i.kind == REQ_RANGE && !sts_i.div_zero) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_off = OFF_I;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.seed_wr  = accept && (sts_i.in_kind == REQ_SEED);
        cmd_o.req_load = accept && (sts_i.in_kind != REQ_SEED);
      end
      ST_RD0: cmd_o.rd_off = OFF_I;
      ST_RD1: begin
        cmd_o.rd_off = OFF_13;
        cmd_o.cap_v0 = 1'b1;
      end
      ST_RD2: begin
        cmd_o.rd_off  = OFF_9;
        cmd_o.cap_vm1 = 1'b1;
      end
      ST_RD3: begin
        cmd_o.rd_off  = OFF_15;
        cmd_o.cap_vm2 = 1'b1;
      end
      ST_CAP:  cmd_o.cap_z0 = 1'b1;
      ST_MIX:  cmd_o.mix = 1'b1;
      ST_WR0:  cmd_o.wr0 = 1'b1;
      ST_WR1:  cmd_o.wr1 = 1'b1;
      ST_POST: begin
        cmd_o.div_start = 1'b1;
        cmd_o.frac_mul  = 1'b1;
      end
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_FIN:  cmd_o.out_load = sts_i.out_free;
      default: cmd_o.rd_off = OFF_I;
    endcase
  end

endmodule

>>> hw/rtl/well512_random_generator.sv
// ----------------------------------------------------------------------------
// well512_random_generator
// well512a generator with seed load, raw, range and fraction draws
// ----------------------------------------------------------------------------
// One request per input transaction. A seed load writes one pool word in the
// cycle it is accepted and the next request can follow at once. A raw or
// fraction draw runs through four reads on the single pool read port, the
// mix, two pool writes and the output stage. A range draw adds the bit-serial
// remainder unit, which is skipped when the range is empty. A finished result
// waits in the output register while the next request is accepted. Pool words
// read as zero until first written.
`timescale 1ns / 1ps

module well512_random_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // lo_bound[31:0], hi_bound[63:32], seed_index[67:64], seed_value[99:68]
  input  logic [103:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rand_value[31:0], unit_fraction[54:32]
  output logic [55:0]  m_axis_tdata,
  // bad_request[0]
  output logic [0:0]   m_axis_tuser
);
  import w512_pkg::*;

  w512_cmd_t        cmd;
  w512_sts_t        sts;
  logic [WordW-1:0] rand_value;
  logic [FracW-1:0] unit_fraction;
  logic             bad_request;

  w512_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  w512_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (s_axis_tuser),
    .lo_bound_i      (s_axis_tdata[31:0]),
    .hi_bound_i      (s_axis_tdata[63:32]),
    .seed_index_i    (s_axis_tdata[67:64]),
    .seed_value_i    (s_axis_tdata[99:68]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .rand_value_o    (rand_value),
    .unit_fraction_o (unit_fraction),
    .bad_request_o   (bad_request)
  );

  assign m_axis_tdata = {1'b0, unit_fraction, rand_value};
  assign m_axis_tuser = bad_request;

endmodule

>>> tb/w512_draw_checker.sv
// ----------------------------------------------------------------------------
// w512_draw_checker
// watches both stream channels of the well512a generator, keeps its own copy
// of the pool and index, predicts each draw result and compares it field by
// field with the result transactions in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module w512_draw_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // lo_bound[31:0], hi_bound[63:32], seed_index[67:64], seed_value[99:68]
  input  logic [103:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rand_value[31:0], unit_fraction[54:32]
  input  logic [55:0]  m_axis_tdata,
  // bad_request[0]
  input  logic [0:0]   m_axis_tuser,
  output int unsigned  mismatch_cnt_o,
  output int unsigned  draws_open_o
);
  import w512_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [22:0] frac;
    logic        bad;
  } draw_t;

  logic [31:0] pool_q [16];
  logic [3:0]  pool_idx_q;
  draw_t       open_draws_q [$];
  int unsigned mismatch_n;

  // one step of the well512a recurrence, returns the drawn word
  function automatic logic [31:0] well_advance();
    logic [3:0]  i0, i13, i9, i15;
    logic [31:0] v0, vm1, vm2, z0, z1, z2, n1, n0;
    i0  = pool_idx_q;
    i13 = i0 + 4'd13;
    i9  = i0 + 4'd9;
    i15 = i0 + 4'd15;
    v0  = pool_q[i0];
    vm1 = pool_q[i13];
    vm2 = pool_q[i9];
    z0  = pool_q[i15];
    z1  = v0 ^ (v0 << 16) ^ vm1 ^ (vm1 << 15);
    z2  = vm2 ^ (vm2 >> 11);
    n1  = z1 ^ z2;
    n0  = z0 ^ (z0 << 2) ^ z1 ^ (z1 << 18) ^ (z2 << 28) ^ n1 ^ ((n1 << 5) & WellMask);
    pool_q[i0]  = n1;
    pool_q[i15] = n0;
    pool_idx_q  = i15;
    return n0;
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    mismatch_n++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    w512_req_e   kind;
    logic [31:0] lo, hi, span, v, prod;
    draw_t       want, got;
    int          k;
    if (!rst_ni) begin
      for (k = 0; k < 16; k++) pool_q[k] = '0;
      pool_idx_q = '0;
      open_draws_q.delete();
      mismatch_n = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        kind = w512_req_e'(s_axis_tuser);
        lo   = s_axis_tdata[31:0];
        hi   = s_axis_tdata[63:32];
        if (kind == REQ_SEED) begin
          pool_q[s_axis_tdata[67:64]] = s_axis_tdata[99:68];
        end else begin
          v    = well_advance();
          want = '0;
          case (kind)
            REQ_RAW: begin
              want.value = v;
            end
            REQ_RANGE: begin
              span = hi - lo;
              if (span == 32'd0) want.bad = 1'b1;
              else want.value = lo + (v % span);
            end
            default: begin
              prod = v * {17'd0, FracMult};
              if (prod[22:0] == 23'd0) want.bad = 1'b1;
              else want.frac = prod[22:0] - 23'd1;
            end
          endcase
          open_draws_q.push_back(want);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata[31:0];
        got.frac  = m_axis_tdata[54:32];
        got.bad   = m_axis_tuser[0];
        if (open_draws_q.size() == 0) begin
          report("unexpected result, value", 32'd0, got.value);
        end else begin
          want = open_draws_q.pop_front();
          if (got.value !== want.value) report("rand_value", want.value, got.value);
          if (got.frac !== want.frac) report("unit_fraction", {9'd0, want.frac}, {9'd0, got.frac});
          if (got.bad !== want.bad) report("bad_request", {31'd0, want.bad}, {31'd0, got.bad});
        end
      end
    end
    mismatch_cnt_o <= mismatch_n;
    draws_open_o   <= open_draws_q.size();
  end

endmodule

>>> tb/tb_well512_random_generator.sv
// ----------------------------------------------------------------------------
// tb_well512_random_generator
// drives seed loads and raw, range and fraction draws into the generator with
// bursty input traffic and a stalling result side, and takes the verdict from
// the draw checker that runs beside the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_well512_random_generator;
  import w512_pkg::*;

  localparam int unsigned RandomItems = 1350;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [55:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  int unsigned  mismatch_cnt;
  int unsigned  draws_open;

  int unsigned  sent_n;
  int unsigned  burst_left;

  well512_random_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  w512_draw_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_cnt_o (mismatch_cnt),
    .draws_open_o   (draws_open)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // one request transaction, then the burst bookkeeping
  task automatic send_req(input w512_req_e kind, input logic [31:0] lo, input logic [31:0] hi,
                          input logic [3:0] idx, input logic [31:0] val);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'd0, val, idx, hi, lo};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_n++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_all_drawn();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (draws_open != 0) @(posedge clk_i);
  endtask

  task automatic send_draw();
    w512_req_e   kind;
    logic [31:0] lo, hi;
    int unsigned sel;
    sel = $urandom_range(0, 2);
    case (sel)
      0:       kind = REQ_RAW;
      1:       kind = REQ_RANGE;
      default: kind = REQ_FRAC;
    endcase
    lo  = $urandom;
    hi  = $urandom;
    sel = $urandom_range(0, 9);
    case (sel)
      0: hi = lo;
      1: hi = lo + $urandom_range(1, 16);
      2: if (hi > lo) {lo, hi} = {hi, lo};
      3: begin
        lo = $urandom_range(0, 1) ? 32'hffffffff : 32'd0;
        hi = $urandom_range(0, 1) ? 32'hffffffff : 32'd0;
      end
      default: ;
    endcase
    send_req(kind, lo, hi, 4'($urandom), $urandom);
  endtask

  task automatic reseed_pool();
    int unsigned n;
    bit          zeros, whole;
    int          k;
    whole = $urandom_range(0, 1);
    zeros = whole && ($urandom_range(0, 9) == 0);
    n     = whole ? 16 : $urandom_range(1, 8);
    for (k = 0; k < n; k++) begin
      send_req(REQ_SEED, $urandom, $urandom, whole ? 4'(k) : 4'($urandom),
               zeros ? 32'd0 : $urandom);
    end
  endtask

  initial begin : stim
    int  k;
    bit  paused_mid;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_SEED;
    sent_n     = 0;
    burst_left = 4;
    paused_mid = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unseeded pool draws zero, so this fraction hits the masked-zero case
    send_req(REQ_FRAC, 32'd0, 32'd0, 4'd0, 32'd0);
    send_req(REQ_RAW, 32'd0, 32'd0, 4'd0, 32'd0);
    send_req(REQ_RANGE, 32'h1234, 32'h1234, 4'd0, 32'd0);
    send_req(REQ_RANGE, 32'd5, 32'd10, 4'd0, 32'd0);
    for (k = 0; k < 16; k++) begin
      send_req(REQ_SEED, $urandom, $urandom, 4'(k),
               (k == 0) ? 32'hffffffff : ((k == 15) ? 32'd0 : $urandom));
    end
    send_req(REQ_RAW, 32'd0, 32'd0, 4'hf, 32'hffffffff);
    send_req(REQ_RANGE, 32'd0, 32'hffffffff, 4'd0, 32'd0);
    send_req(REQ_RANGE, 32'hffffffff, 32'd0, 4'd0, 32'd0);
    send_req(REQ_FRAC, 32'd0, 32'd0, 4'd0, 32'd0);
    send_req(REQ_RANGE, 32'h80000000, 32'h7fffffff, 4'd0, 32'd0);
    wait_all_drawn();

    while (sent_n < RandomItems) begin
      if ($urandom_range(0, 7) == 0) reseed_pool();
      repeat ($urandom_range(4, 20)) send_draw();
      if (!paused_mid && sent_n > RandomItems / 2) begin
        wait_all_drawn();
        paused_mid = 1'b1;
      end
    end

    wait_all_drawn();
    repeat (60) @(posedge clk_i);
    if (mismatch_cnt == 0 && draws_open == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side stall patterns, with one long hold-off
  initial begin : rx
    int unsigned mode, span, seen, tick, period;
    bit          held;
    m_axis_tready <= 1'b0;
    seen = 0;
    tick = 0;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(10, 150);
      period = $urandom_range(1, 6);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        if (m_axis_tvalid && m_axis_tready) seen++;
        if (!held && seen >= 80) begin
          held = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (400) @(posedge clk_i);
        end
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((tick / period) % 2 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
